FILE: sv/signed_int_to_decimal_ascii_assert.svh
// Assertion macros for the signed integer to decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SITDA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SITDA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/sitda_pkg.sv
// Package with shared types, constants and the BCD adjust function.
`timescale 1ns / 1ps

package sitda_pkg;

	localparam int DATA_W = 32;
	localparam int DIGITS = 10;
	localparam int BCD_W  = 4 * DIGITS;
	localparam int CNT_W  = $clog2(DATA_W);
	localparam int REM_W  = $clog2(DIGITS + 1);

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef logic [3:0]       digit_t;
	typedef logic [BCD_W-1:0] bcd_t;

	// Result of one conversion handed from the converter to the emitter.
	typedef struct packed {
		logic neg;
		bcd_t bcd;
	} conv_res_t;

	// Add three to every BCD digit of five or more, ahead of the next shift.
	function automatic bcd_t dabble_adj(input bcd_t b);
		bcd_t   r;
		digit_t d;
		r = b;
		for (int i = 0; i < DIGITS; i++) begin
			d = b[4*i +: 4];
			if (d >= 4'd5) begin
				r[4*i +: 4] = d + 4'd3;
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/sitda_in_if.sv
// Input channel: one signed 32-bit value per item.
`timescale 1ns / 1ps

interface sitda_in_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

FILE: sv/sitda_out_if.sv
// Output channel: one ASCII character and its last flag per item.
`timescale 1ns / 1ps

interface sitda_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink (input valid, input char_code, input last, output ready);
endinterface

FILE: sv/sitda_conv.sv
// Bit-serial binary to BCD converter using shift-and-add-3.
`timescale 1ns / 1ps

module sitda_conv (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [31:0]    in_value,
	output logic                  res_valid,
	input  logic                  res_ready,
	output sitda_pkg::conv_res_t  res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                   state_q;
	logic [sitda_pkg::CNT_W-1:0]  cnt_q;
	logic [sitda_pkg::DATA_W-1:0] mag_q;
	sitda_pkg::bcd_t              bcd_q;
	logic                         neg_q;
	logic [sitda_pkg::DATA_W-1:0] raw;
	logic [sitda_pkg::DATA_W-1:0] mag_in;
	sitda_pkg::bcd_t              bcd_adj;

	// Magnitude of the incoming value; the most negative value wraps to itself.
	assign raw    = in_value;
	assign mag_in = raw[sitda_pkg::DATA_W-1] ? (sitda_pkg::DATA_W'(0) - raw) : raw;

	assign bcd_adj = sitda_pkg::dabble_adj(bcd_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res.neg   = neg_q;
	assign res.bcd   = bcd_q;

	// Control: load, one magnitude bit per cycle, then hold until handed over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == sitda_pkg::CNT_W'(sitda_pkg::DATA_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: magnitude shifts out at the top and into the BCD register.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			mag_q <= mag_in;
			neg_q <= raw[sitda_pkg::DATA_W-1];
			bcd_q <= '0;
		end else if (state_q == ST_RUN) begin
			mag_q <= {mag_q[sitda_pkg::DATA_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[sitda_pkg::BCD_W-2:0], mag_q[sitda_pkg::DATA_W-1]};
		end
	end

endmodule

FILE: sv/sitda_emit.sv
// Character serializer: sign, then digits with leading zeros dropped.
`timescale 1ns / 1ps

module sitda_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	output logic                 res_ready,
	input  sitda_pkg::conv_res_t res,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_char,
	output logic                 out_last
);

	logic                        busy_q;
	logic                        sign_q;
	logic                        started_q;
	logic [sitda_pkg::REM_W-1:0] rem_q;
	sitda_pkg::bcd_t             bcd_q;
	logic                        out_valid_q;
	logic [7:0]                  out_char_q;
	logic                        out_last_q;
	sitda_pkg::digit_t           top_dig;
	logic                        adv;
	logic                        skip;
	logic                        final_dig;
	logic                        emit;

	assign top_dig   = bcd_q[sitda_pkg::BCD_W-1 -: 4];
	assign final_dig = (rem_q == sitda_pkg::REM_W'(1));
	assign adv       = busy_q && (!out_valid_q || out_ready);
	assign skip      = !sign_q && !started_q && (top_dig == 4'd0) && !final_dig;
	assign emit      = adv && (sign_q || !skip);

	assign res_ready = !busy_q;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	// Control: walk the digits from the most significant end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			sign_q      <= 1'b0;
			started_q   <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register fills with a new character and empties once it is taken.
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (!busy_q && res_valid) begin
				busy_q    <= 1'b1;
				sign_q    <= res.neg;
				started_q <= 1'b0;
				rem_q     <= sitda_pkg::REM_W'(sitda_pkg::DIGITS);
			end else if (adv) begin
				priority if (sign_q) begin
					sign_q <= 1'b0;
				end else if (skip) begin
					rem_q <= rem_q - 1'b1;
				end else begin
					rem_q     <= rem_q - 1'b1;
					started_q <= 1'b1;
					if (final_dig) begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	// Datapath: digit shift register and the output register.
	always_ff @(posedge clk) begin
		if (!busy_q && res_valid) begin
			bcd_q <= res.bcd;
		end else if (adv) begin
			if (sign_q) begin
				out_char_q <= sitda_pkg::CHAR_MINUS;
				out_last_q <= 1'b0;
			end else begin
				bcd_q <= {bcd_q[sitda_pkg::BCD_W-5:0], 4'd0};
				if (!skip) begin
					out_char_q <= sitda_pkg::CHAR_ZERO + {4'd0, top_dig};
					out_last_q <= final_dig;
				end
			end
		end
	end

endmodule

FILE: sv/signed_int_to_decimal_ascii.sv
// Flow: an accepted value is loaded, runs the 32-step shift-and-add-3 loop, is handed to the
// emitter and leaves its output register; a positive value's first character also waits while
// each dropped leading zero is shifted out. The converter takes a new value only once its
// result is handed over; characters leave at up to one per cycle, when the output is ready,
// while the next value converts. Each value gives 1 to 11 characters.
// Reset: arst_n clears all control state asynchronously; no item is in flight afterward.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
	input  logic  clk,
	input  logic  arst_n,
	sitda_in_if.sink    in_ch,
	sitda_out_if.source out_ch
);

	logic                 conv_res_valid;
	logic                 emit_ready;
	sitda_pkg::conv_res_t conv_res;

	// Bit-serial binary to BCD conversion.
	sitda_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_value  (in_ch.value),
		.res_valid (conv_res_valid),
		.res_ready (emit_ready),
		.res       (conv_res)
	);

	// Character emission, overlapped with the next conversion.
	sitda_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (conv_res_valid),
		.res_ready (emit_ready),
		.res       (conv_res),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_char  (out_ch.char_code),
		.out_last  (out_ch.last)
	);

	// The converter takes new input only when it holds no finished result.
	`SITDA_ASSERT_IMP(a_idle_no_result, clk, arst_n, in_ch.ready, !conv_res_valid, "converter accepts input while holding a result")

	// A handed-over result leaves the converter in the next cycle.
	`SITDA_ASSERT_NXT(a_handover, clk, arst_n, conv_res_valid && emit_ready, !conv_res_valid, "conversion result handed over twice")

	// Every character is a minus sign or a decimal digit.
	`SITDA_ASSERT_IMP(a_char_code, clk, arst_n, out_ch.valid, (out_ch.char_code == sitda_pkg::CHAR_MINUS) || ((out_ch.char_code >= sitda_pkg::CHAR_ZERO) && (out_ch.char_code <= sitda_pkg::CHAR_ZERO + 8'd9)), "character is not a sign or digit")

	// A minus sign is always followed by digits.
	`SITDA_ASSERT_IMP(a_minus_not_last, clk, arst_n, out_ch.valid && (out_ch.char_code == sitda_pkg::CHAR_MINUS), !out_ch.last, "minus sign flagged as last character")

endmodule
